// ===== sv/ecig_pkg.sv =====
// Package for the edit-list-to-CIGAR unit: operation codes, field widths,
// port payload structs and the raw-edit record passed from front to back.
// No dependencies.
package ecig_pkg;

    localparam int EDIT_LEN_W = 16;
    localparam int OP_LEN_W   = 20;

    localparam logic [OP_LEN_W-1:0] LEN_MAX = {OP_LEN_W{1'b1}};

    // CIGAR operation codes.
    localparam logic [1:0] CODE_M = 2'd0;
    localparam logic [1:0] CODE_I = 2'd1;
    localparam logic [1:0] CODE_D = 2'd2;
    localparam logic [1:0] CODE_S = 2'd3;

    // Input transaction: one alignment edit.
    typedef struct packed {
        logic [EDIT_LEN_W-1:0] edit_from_length;
        logic [EDIT_LEN_W-1:0] edit_to_length;
        logic                  end_of_path;
    } t_edit;

    // Output transaction: one merged CIGAR operation.
    typedef struct packed {
        logic [OP_LEN_W-1:0] op_length;
        logic [1:0]          op_code;
        logic                last_op;
    } t_cigar_op;

    // One raw operation with its final code.
    typedef struct packed {
        logic [EDIT_LEN_W-1:0] len;
        logic [1:0]            code;
    } t_raw_op;

    // A classified edit: one or two raw operations in emission order.
    typedef struct packed {
        t_raw_op op0;
        t_raw_op op1;
        logic    op1_valid;
        logic    end_of_path;
    } t_raw_edit;

endpackage

// ===== sv/ecig_fifo.sv =====
// Small synchronous FIFO of register entries, used for the raw-edit queue
// and for the result queue. Depends on nothing but its type parameter.
module ecig_fifo #(
    parameter int  DEPTH  = 4,
    parameter type t_data = logic
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_wr,
    input  t_data i_wr_data,
    output logic  o_full,
    input  logic  i_rd,
    output t_data o_rd_data,
    output logic  o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_data            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             w_do_wr, w_do_rd;

    assign o_full    = (r_count == FULL_CNT);
    assign o_empty   = (r_count == '0);
    assign w_do_wr   = i_wr && !o_full;
    assign w_do_rd   = i_rd && !o_empty;
    assign o_rd_data = r_mem[r_rd_ptr];

    // Pointer and occupancy update.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_do_wr) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (w_do_rd) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (w_do_wr && !w_do_rd) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_do_rd && !w_do_wr) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage carries no reset.
    always_ff @(posedge i_clk) begin
        if (w_do_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

// ===== sv/ecig_front.sv =====
// Front end: holds the order register and the start-of-path flag, and
// splits each accepted edit into its raw CIGAR operations. Uses ecig_pkg.
module ecig_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic               i_cfg_wr_data,
    input  logic               i_accept,
    input  ecig_pkg::t_edit    i_edit,
    output ecig_pkg::t_raw_edit o_entry
);
    import ecig_pkg::*;

    logic                  r_reverse_order;
    logic                  r_at_start;
    logic [EDIT_LEN_W-1:0] w_from, w_to, w_shared, w_diff;
    logic                  w_gt, w_eq, w_shared_zero, w_last;
    logic [1:0]            w_indel;

    // An insertion at either end of the path becomes a soft clip.
    function automatic logic [1:0] clip_code(input logic [1:0] code,
                                             input logic at_start,
                                             input logic is_last);
        logic [1:0] res;
        res = code;
        if (code == CODE_I && (at_start || is_last)) begin
            res = CODE_S;
        end
        return res;
    endfunction

    assign w_from        = i_edit.edit_from_length;
    assign w_to          = i_edit.edit_to_length;
    assign w_last        = i_edit.end_of_path;
    assign w_eq          = (w_from == w_to);
    assign w_gt          = (w_from > w_to);
    assign w_shared      = w_gt ? w_to : w_from;
    assign w_diff        = w_gt ? (w_from - w_to) : (w_to - w_from);
    assign w_indel       = w_gt ? CODE_D : CODE_I;
    assign w_shared_zero = (w_shared == '0);

    // Classification of the edit into one or two raw operations.
    always_comb begin
        o_entry.end_of_path = w_last;
        o_entry.op1         = '{len: w_shared, code: CODE_M};
        o_entry.op1_valid   = 1'b0;
        if (w_eq) begin
            o_entry.op0 = '{len: w_from, code: CODE_M};
        end else if (r_reverse_order) begin
            o_entry.op0 = '{len: w_diff,
                            code: clip_code(w_indel, r_at_start, w_last && w_shared_zero)};
            o_entry.op1_valid = !w_shared_zero;
        end else if (!w_shared_zero) begin
            o_entry.op0       = '{len: w_shared, code: CODE_M};
            o_entry.op1       = '{len: w_diff, code: clip_code(w_indel, 1'b0, w_last)};
            o_entry.op1_valid = 1'b1;
        end else begin
            o_entry.op0 = '{len: w_diff, code: clip_code(w_indel, r_at_start, w_last)};
        end
    end

    // Order register and path-start tracking.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reverse_order <= 1'b0;
            r_at_start      <= 1'b1;
        end else begin
            if (i_cfg_wr_en) begin
                r_reverse_order <= i_cfg_wr_data;
            end
            if (i_accept) begin
                r_at_start <= w_last;
            end
        end
    end

endmodule

// ===== sv/ecig_back.sv =====
// Back end: takes classified edits from the queue, merges runs of equal
// code with saturation and writes finished operations out. Uses ecig_pkg.
module ecig_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ecig_pkg::t_raw_edit i_entry,
    input  logic                i_q_empty,
    output logic                o_q_pop,
    input  logic                i_res_full,
    output logic                o_res_wr,
    output ecig_pkg::t_cigar_op o_res
);
    import ecig_pkg::*;

    // Step within the current edit.
    localparam logic [1:0] PH_OP0   = 2'd0;
    localparam logic [1:0] PH_OP1   = 2'd1;
    localparam logic [1:0] PH_FLUSH = 2'd2;

    logic [1:0]          r_phase, n_phase;
    logic [OP_LEN_W-1:0] r_pend_len, n_pend_len;
    logic [1:0]          r_pend_code, n_pend_code;
    logic                r_pend_valid, n_pend_valid;
    logic                w_go;
    t_raw_op             w_op;
    logic [OP_LEN_W:0]   w_sum;

    assign w_go  = !i_q_empty && !i_res_full;
    assign w_op  = (r_phase == PH_OP1) ? i_entry.op1 : i_entry.op0;
    assign w_sum = {1'b0, r_pend_len} + {{(OP_LEN_W + 1 - EDIT_LEN_W){1'b0}}, w_op.len};

    assign o_res.op_length = r_pend_len;
    assign o_res.op_code   = r_pend_code;
    assign o_res.last_op   = (r_phase == PH_FLUSH);

    // One raw operation or the end-of-path flush per cycle while an edit is queued and the result queue is not full.
    always_comb begin
        n_phase      = r_phase;
        n_pend_len   = r_pend_len;
        n_pend_code  = r_pend_code;
        n_pend_valid = r_pend_valid;
        o_res_wr     = 1'b0;
        o_q_pop      = 1'b0;
        unique case (r_phase)
            PH_OP0, PH_OP1: begin
                if (w_go) begin
                    if (r_pend_valid && r_pend_code == w_op.code) begin
                        n_pend_len = w_sum[OP_LEN_W] ? LEN_MAX : w_sum[OP_LEN_W-1:0];
                    end else begin
                        o_res_wr     = r_pend_valid;
                        n_pend_len   = {{(OP_LEN_W - EDIT_LEN_W){1'b0}}, w_op.len};
                        n_pend_code  = w_op.code;
                        n_pend_valid = 1'b1;
                    end
                    if (r_phase == PH_OP0 && i_entry.op1_valid) begin
                        n_phase = PH_OP1;
                    end else if (i_entry.end_of_path) begin
                        n_phase = PH_FLUSH;
                    end else begin
                        n_phase = PH_OP0;
                        o_q_pop = 1'b1;
                    end
                end
            end
            PH_FLUSH: begin
                if (w_go) begin
                    o_res_wr     = r_pend_valid;
                    n_pend_len   = '0;
                    n_pend_code  = CODE_M;
                    n_pend_valid = 1'b0;
                    n_phase      = PH_OP0;
                    o_q_pop      = 1'b1;
                end
            end
            default: begin
                n_phase = PH_OP0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_OP0;
            r_pend_len   <= '0;
            r_pend_code  <= CODE_M;
            r_pend_valid <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_pend_len   <= n_pend_len;
            r_pend_code  <= n_pend_code;
            r_pend_valid <= n_pend_valid;
        end
    end

endmodule

// ===== sv/edit_list_to_cigar_unit.sv =====
// Top level of the edit-list-to-CIGAR unit: front end, raw-edit queue, merge
// back end and result queue. Depends on ecig_pkg and the ecig_* modules.
//
// Usage. Edits enter through a queue-style port: a transaction is taken when
// push is high and full is low. CIGAR operations leave through a second queue
// port: the oldest operation is on o_op while empty is low and is taken when
// pop is high. i_cfg_wr_en writes the order bit (1 = edits arrive last first).
// The user must write it only between paths while the unit is idle; the unit
// itself does not enforce this. Flow. An accepted edit is classified and
// registered into the raw-edit queue. The back end handles one raw operation
// (one or two per edit) or the end-of-path flush per cycle while the result
// queue is not full, so plain edits go at one per cycle and split edits and
// path ends take extra steps. A merged run leaves when a different code follows
// or the path ends, and is registered into the result queue when it is closed.
// Reset clears both queues, the pending run and the order bit, and marks the
// next edit as the start of a path. When the receiver stops popping, the
// result queue fills, the back end halts, then the raw-edit queue fills and
// full is raised; nothing is dropped.
module edit_list_to_cigar_unit #(
    parameter int EDIT_QUEUE_DEPTH   = 4,
    parameter int RESULT_QUEUE_DEPTH = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic                i_cfg_wr_data,
    input  logic                push,
    output logic                full,
    input  ecig_pkg::t_edit     i_edit,
    input  logic                pop,
    output logic                empty,
    output ecig_pkg::t_cigar_op o_op
);
    import ecig_pkg::*;

    logic      w_accept;
    t_raw_edit w_entry_in, w_entry_out;
    logic      w_q_empty, w_q_pop;
    logic      w_res_wr, w_res_full;
    t_cigar_op w_res;
    logic      r_prev_open;
    logic [1:0] r_prev_code;

    assign w_accept = push && !full;

    // Front end: classification of each edit.
    ecig_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_accept      (w_accept),
        .i_edit        (i_edit),
        .o_entry       (w_entry_in)
    );

    // Queue of classified edits between front and back.
    ecig_fifo #(
        .DEPTH  (EDIT_QUEUE_DEPTH),
        .t_data (t_raw_edit)
    ) u_edit_q (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (push),
        .i_wr_data (w_entry_in),
        .o_full    (full),
        .i_rd      (w_q_pop),
        .o_rd_data (w_entry_out),
        .o_empty   (w_q_empty)
    );

    // Back end: run merging.
    ecig_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_entry    (w_entry_out),
        .i_q_empty  (w_q_empty),
        .o_q_pop    (w_q_pop),
        .i_res_full (w_res_full),
        .o_res_wr   (w_res_wr),
        .o_res      (w_res)
    );

    // Result queue towards the receiver.
    ecig_fifo #(
        .DEPTH  (RESULT_QUEUE_DEPTH),
        .t_data (t_cigar_op)
    ) u_res_q (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (w_res_wr),
        .i_wr_data (w_res),
        .o_full    (w_res_full),
        .i_rd      (pop),
        .o_rd_data (o_op),
        .o_empty   (empty)
    );

    // Code of the previous operation written within the open path.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_open <= 1'b0;
            r_prev_code <= CODE_M;
        end else if (w_res_wr) begin
            r_prev_open <= !w_res.last_op;
            r_prev_code <= w_res.op_code;
        end
    end

    // The back end never writes into a full result queue.
    a_no_res_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_wr |-> !w_res_full)
        else $error("result written while result queue full");

    // The back end only pops an edit that is present.
    a_no_q_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_pop |-> !w_q_empty)
        else $error("edit queue popped while empty");

    // Within a path, two successive operations never share a code.
    a_runs_merged: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_res_wr && r_prev_open) |-> (w_res.op_code != r_prev_code))
        else $error("adjacent operations with equal code not merged");

endmodule

// ===== dv/ecig_tb_pkg.sv =====
`timescale 1ns / 100ps
// Checker class for the edit-list-to-CIGAR testbench: predicts merged CIGAR
// operations from accepted edits and compares the unit's results with them.
// Depends on ecig_pkg.
package ecig_tb_pkg;
    import ecig_pkg::*;

    class cigar_op_checker;
        bit                  order_rev;
        logic [OP_LEN_W-1:0] run_len;
        logic [1:0]          run_code;
        bit                  run_open;
        bit                  path_start;
        t_cigar_op           expected_ops[$];
        int                  errors;

        function new();
            order_rev  = 1'b0;
            run_len    = '0;
            run_code   = CODE_M;
            run_open   = 1'b0;
            path_start = 1'b1;
            errors     = 0;
        endfunction

        // The order bit applies to every edit noted after the write.
        function void set_order(bit rev);
            order_rev = rev;
        endfunction

        function int outstanding();
            return expected_ops.size();
        endfunction

        // Closes the open run and queues it as an expected operation.
        function void close_run(bit last);
            t_cigar_op op;
            op.op_length = run_len;
            op.op_code   = run_code;
            op.last_op   = last;
            expected_ops.insert(expected_ops.size(), op);
        endfunction

        // Adds one raw operation. An insertion at either end of the path becomes a
        // soft clip, and an operation with the same code as the open run extends it.
        function void add_raw(logic [EDIT_LEN_W-1:0] len, logic [1:0] code, bit is_last);
            logic [1:0]        final_code;
            logic [OP_LEN_W:0] sum;
            final_code = code;
            if (code == CODE_I && (path_start || is_last)) begin
                final_code = CODE_S;
            end
            path_start = 1'b0;
            if (run_open && run_code == final_code) begin
                sum = {1'b0, run_len} + (OP_LEN_W + 1)'(len);
                run_len = (sum > {1'b0, LEN_MAX}) ? LEN_MAX : sum[OP_LEN_W-1:0];
            end else begin
                if (run_open) begin
                    close_run(1'b0);
                end
                run_len  = OP_LEN_W'(len);
                run_code = final_code;
                run_open = 1'b1;
            end
        endfunction

        // Splits an accepted edit into raw operations and flushes at the path end.
        function void note_edit(t_edit e);
            logic [EDIT_LEN_W-1:0] shared;
            logic [EDIT_LEN_W-1:0] diff;
            logic [1:0]            indel;
            bit                    fin;
            fin = e.end_of_path;
            if (e.edit_from_length == e.edit_to_length) begin
                add_raw(e.edit_from_length, CODE_M, fin);
            end else begin
                if (e.edit_from_length > e.edit_to_length) begin
                    shared = e.edit_to_length;
                    diff   = e.edit_from_length - e.edit_to_length;
                    indel  = CODE_D;
                end else begin
                    shared = e.edit_from_length;
                    diff   = e.edit_to_length - e.edit_from_length;
                    indel  = CODE_I;
                end
                if (order_rev) begin
                    add_raw(diff, indel, fin && shared == 0);
                    if (shared != 0) begin
                        add_raw(shared, CODE_M, fin);
                    end
                end else begin
                    if (shared != 0) begin
                        add_raw(shared, CODE_M, 1'b0);
                    end
                    add_raw(diff, indel, fin);
                end
            end
            if (fin) begin
                if (run_open) begin
                    close_run(1'b1);
                end
                run_open   = 1'b0;
                run_len    = '0;
                run_code   = CODE_M;
                path_start = 1'b1;
            end
        endfunction

        // Compares one popped operation with the oldest expected one.
        function void check_op(t_cigar_op got);
            t_cigar_op want;
            if (expected_ops.size() == 0) begin
                $display("%0t: expected no operation, actual length %0d code %0d last %0b",
                         $time, got.op_length, got.op_code, got.last_op);
                errors++;
                return;
            end
            want = expected_ops.pop_front();
            if (got.op_length !== want.op_length) begin
                $display("%0t: op_length expected %0d actual %0d",
                         $time, want.op_length, got.op_length);
                errors++;
            end
            if (got.op_code !== want.op_code) begin
                $display("%0t: op_code expected %0d actual %0d",
                         $time, want.op_code, got.op_code);
                errors++;
            end
            if (got.last_op !== want.last_op) begin
                $display("%0t: last_op expected %0b actual %0b",
                         $time, want.last_op, got.last_op);
                errors++;
            end
        endfunction
    endclass

endpackage

// ===== dv/edit_list_to_cigar_unit_tb.sv =====
`timescale 1ns / 100ps
// Testbench top for edit_list_to_cigar_unit: directed and random edit paths in
// both orders, bursty sending and a stalling receiver. Depends on ecig_pkg and
// ecig_tb_pkg.
module edit_list_to_cigar_unit_tb;
    import ecig_pkg::*;
    import ecig_tb_pkg::*;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_cfg_wr_en;
    logic      i_cfg_wr_data;
    logic      push;
    logic      full;
    t_edit     i_edit;
    logic      pop;
    logic      empty;
    t_cigar_op o_op;

    cigar_op_checker checker_h;
    int              burst_left;
    int              rx_cycle;

    edit_list_to_cigar_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .push         (push),
        .full         (full),
        .i_edit       (i_edit),
        .pop          (pop),
        .empty        (empty),
        .o_op         (o_op)
    );

    // Clock with an 8 ns period.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Receiver: checks each popped transaction and stalls on a shifting pattern.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                checker_h.check_op(o_op);
            end
            rx_cycle++;
            case ((rx_cycle / 97) % 4)
                0: pop <= 1'b1;
                1: pop <= 1'($urandom_range(0, 1));
                2: pop <= ($urandom_range(0, 7) != 0);
                default: pop <= ((rx_cycle / 13) % 3) != 0;
            endcase
        end
    end

    // Sends one edit and waits for its acceptance; ends the burst with a gap.
    task automatic drive_edit(input t_edit e);
        i_edit <= e;
        push   <= 1'b1;
        @(posedge i_clk);
        while (full) begin
            @(posedge i_clk);
        end
        checker_h.note_edit(e);
        burst_left--;
        if (burst_left <= 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                      : $urandom_range(1, 10);
        end
    endtask

    task automatic send(input int from_len, input int to_len, input bit last);
        t_edit e;
        e.edit_from_length = EDIT_LEN_W'(from_len);
        e.edit_to_length   = EDIT_LEN_W'(to_len);
        e.end_of_path      = last;
        drive_edit(e);
    endtask

    // Holds the sender until every expected operation has been popped.
    task automatic drain();
        push <= 1'b0;
        while (checker_h.outstanding() != 0) begin
            @(posedge i_clk);
        end
        repeat (16) @(posedge i_clk);
    endtask

    task automatic write_order(input bit rev);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= rev;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        checker_h.set_order(rev);
    endtask

    // Mostly short lengths, with full-range and extreme values mixed in.
    function automatic int pick_len();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom_range(0, 15);
            4, 5, 6:    return $urandom_range(0, 300);
            7:          return $urandom_range(0, 1) ? 65535 : 0;
            default:    return $urandom_range(0, 65535);
        endcase
    endfunction

    // One random path of well-formed edits ending in a last edit.
    task automatic send_path(input int n_edits);
        int f;
        int t;
        for (int k = 0; k < n_edits; k++) begin
            if ($urandom_range(0, 9) == 0) begin
                f = 0;
                t = 0;
            end else begin
                f = pick_len();
                t = ($urandom_range(0, 3) == 0) ? f : pick_len();
            end
            send(f, t, k == n_edits - 1);
            if ($urandom_range(0, 39) == 0) begin
                drain();
            end
        end
    endtask

    initial begin
        int sent;
        int n_edits;
        checker_h     = new();
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = 1'b0;
        push          = 1'b0;
        pop           = 1'b0;
        i_edit        = '0;
        burst_left    = 3;
        rx_cycle      = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Forward order: empty edit alone, empty edit merged, clips and splits.
        write_order(1'b0);
        send(0, 0, 1'b1);
        send(10, 10, 1'b0);
        send(0, 0, 1'b1);
        send(0, 3, 1'b0);
        send(0, 4, 1'b0);
        send(7, 7, 1'b0);
        send(0, 2, 1'b1);
        send(8, 3, 1'b0);
        send(3, 8, 1'b1);
        // Seventeen maximal matches saturate the run length.
        for (int k = 0; k < 17; k++) begin
            send(65535, 65535, 1'b0);
        end
        send(0, 65535, 1'b1);
        drain();

        // Reverse order, then an order change in the middle of a path.
        write_order(1'b1);
        send(3, 8, 1'b0);
        send(8, 3, 1'b0);
        send(0, 4, 1'b1);
        send(2, 5, 1'b0);
        drain();
        write_order(1'b0);
        send(5, 2, 1'b1);
        drain();

        // Random paths in segments that alternate the order bit.
        for (int seg = 0; seg < 6; seg++) begin
            write_order(seg[0]);
            sent = 0;
            while (sent < 22) begin
                n_edits = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 20)
                                                      : $urandom_range(1, 8);
                send_path(n_edits);
                sent += n_edits;
            end
            drain();
        end

        repeat (20) @(posedge i_clk);
        if (checker_h.errors == 0 && checker_h.outstanding() == 0) begin
            $display("edit_list_to_cigar_unit: match");
        end else begin
            $display("edit_list_to_cigar_unit: mismatch");
        end
        $finish;
    end

    // Watchdog for a hung handshake or a missing result.
    initial begin
        #2000000;
        $display("edit_list_to_cigar_unit: mismatch");
        $finish;
    end

endmodule
